/* hw/rtl/shared_buffer_multi_queue_defines.svh */
// assertion macros for the shared buffer multi-queue checker
// no dependencies; included by sbmq_checker.sv
`ifndef SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH
`define SHARED_BUFFER_MULTI_QUEUE_DEFINES_SVH

// same-cycle implication
`define SBMQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sbmq_pkg.sv */
// shared types, codes and defaults for the shared buffer multi-queue
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sbmq_pkg;

	localparam int DEF_NUM_SLOTS  = 64;
	localparam int DEF_NUM_QUEUES = 8;

	localparam int DATA_W  = 32;
	localparam int QID_IN_W = 3;
	localparam int AQ_W    = 4;

	localparam logic [AQ_W-1:0]   ACTIVE_QUEUES_RST = 4'd8;
	localparam logic [DATA_W-1:0] ERR_DATA          = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] ENQ_DATA          = 32'h0000_0000;

	// word index of the register on the config port
	localparam logic REG_ACTIVE_QUEUES = 1'b0;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BADQ  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PTR,
		BK_LINK
	} back_state_t;

	// one classified item between front and back
	typedef struct packed {
		logic                op;
		logic [QID_IN_W-1:0] qid;
		logic [DATA_W-1:0]   din;
		logic                badq;
	} item_t;

endpackage

/* hw/rtl/sbmq_front.sv */
// front end: accepts items, flags bad queue indices, two-entry item queue
// depends on sbmq_pkg
`timescale 1ns / 1ps

module sbmq_front #(
	parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [sbmq_pkg::QID_IN_W-1:0] queue_id,
	input  logic [sbmq_pkg::DATA_W-1:0]   data_in,
	input  logic [sbmq_pkg::AQ_W-1:0]     active_queues,
	output logic                          item_valid,
	output sbmq_pkg::item_t               item,
	input  logic                          item_pop
);
	import sbmq_pkg::*;

	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      new_item;

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rd_q];

	always_comb begin
		new_item.op   = opcode;
		new_item.qid  = queue_id;
		new_item.din  = data_in;
		new_item.badq = ({1'b0, queue_id} >= active_queues) ||
			(32'(queue_id) >= 32'(NUM_QUEUES));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (item_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/sbmq_back.sv */
// back end: pointer, link and data memories, free list, result register
// depends on sbmq_pkg
`timescale 1ns / 1ps

module sbmq_back #(
	parameter int NUM_SLOTS  = sbmq_pkg::DEF_NUM_SLOTS,
	parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  sbmq_pkg::item_t             item,
	output logic                        item_pop,
	input  logic                        res_stall,
	output logic                        res_valid,
	output logic [1:0]                  res_status,
	output logic [sbmq_pkg::DATA_W-1:0] res_data
);
	import sbmq_pkg::*;

	localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

	back_state_t state_q, state_d;
	item_t       item_s1;

	logic [PTR_W-1:0]      free_head_q;
	logic [PTR_W-1:0]      fresh_q;
	logic [PTR_W-1:0]      head_q;
	logic [NUM_QUEUES-1:0] qvalid_q;

	// memories and their registered read data
	logic [2*PTR_W-1:0] qptr_mem [NUM_QUEUES];
	logic [PTR_W-1:0]   link_mem [NUM_SLOTS];
	logic [DATA_W-1:0]  data_mem [NUM_SLOTS];
	logic [2*PTR_W-1:0] qrd_q;
	logic [PTR_W-1:0]   lrd_q;
	logic [DATA_W-1:0]  drd_q;

	logic              res_valid_q;
	logic [1:0]        res_status_q;
	logic [DATA_W-1:0] res_data_q;

	// decode
	logic [QID_W-1:0]  qidx_in, qidx;
	logic [PTR_W-1:0]  cur_head, cur_tail, next_free;
	logic              head_ok, tail_ok, full, out_ready, deq_go;

	// memory and register controls
	logic               qp_re, qp_we;
	logic [QID_W-1:0]   qp_addr;
	logic [2*PTR_W-1:0] qp_wdata;
	logic               lk_re, lk_we;
	logic [SLOT_W-1:0]  lk_addr;
	logic [PTR_W-1:0]   lk_wdata;
	logic               dt_re, dt_we;
	logic [SLOT_W-1:0]  dt_addr;
	logic               fin;
	status_t            fin_status;
	logic [DATA_W-1:0]  fin_data;
	logic               fh_we;
	logic [PTR_W-1:0]   fh_d;
	logic               fresh_inc, qv_set, head_ld;

	assign qidx_in   = QID_W'(item.qid);
	assign qidx      = QID_W'(item_s1.qid);
	assign cur_head  = qvalid_q[qidx] ? qrd_q[2*PTR_W-1:PTR_W] : NIL;
	assign cur_tail  = qrd_q[PTR_W-1:0];
	assign head_ok   = (cur_head < NIL);
	assign tail_ok   = (cur_tail < NIL);
	assign full      = (free_head_q == NIL);
	// slots never handed out still follow the reset chain
	assign next_free = (free_head_q < fresh_q) ? lrd_q : (free_head_q + PTR_W'(1));
	assign out_ready = !res_valid_q || !res_stall;
	assign deq_go    = !item_s1.badq && (item_s1.op == OP_DEQ) && head_ok;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					state_d = BK_PTR;
				end
			end
			BK_PTR: begin
				if (deq_go) begin
					state_d = BK_LINK;
				end else if (out_ready) begin
					state_d = BK_IDLE;
				end
			end
			BK_LINK: begin
				if (out_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		item_pop   = 1'b0;
		qp_re      = 1'b0;
		qp_we      = 1'b0;
		qp_addr    = qidx;
		qp_wdata   = {cur_head, cur_tail};
		lk_re      = 1'b0;
		lk_we      = 1'b0;
		lk_addr    = free_head_q[SLOT_W-1:0];
		lk_wdata   = NIL;
		dt_re      = 1'b0;
		dt_we      = 1'b0;
		dt_addr    = free_head_q[SLOT_W-1:0];
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_data   = ERR_DATA;
		fh_we      = 1'b0;
		fh_d       = next_free;
		fresh_inc  = 1'b0;
		qv_set     = 1'b0;
		head_ld    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					qp_re    = 1'b1;
					qp_addr  = qidx_in;
					// new tail slot ends its chain; old link is read first
					if ((item.op == OP_ENQ) && !item.badq && !full) begin
						lk_re    = 1'b1;
						lk_we    = 1'b1;
						lk_wdata = NIL;
					end
				end
			end
			BK_PTR: begin
				if (item_s1.badq) begin
					fin        = out_ready;
					fin_status = ST_BADQ;
				end else if (item_s1.op == OP_ENQ) begin
					if (full) begin
						fin        = out_ready;
						fin_status = ST_FULL;
					end else if (out_ready) begin
						fin       = 1'b1;
						fin_data  = ENQ_DATA;
						qp_we     = 1'b1;
						qp_wdata  = {(head_ok ? cur_head : free_head_q), free_head_q};
						qv_set    = 1'b1;
						lk_we     = head_ok && tail_ok;
						lk_addr   = cur_tail[SLOT_W-1:0];
						lk_wdata  = free_head_q;
						dt_we     = 1'b1;
						fh_we     = 1'b1;
						fresh_inc = !(free_head_q < fresh_q);
					end
				end else if (!head_ok) begin
					fin        = out_ready;
					fin_status = ST_EMPTY;
				end else begin
					// unlink head slot and push it on the free list
					lk_re    = 1'b1;
					lk_we    = 1'b1;
					lk_addr  = cur_head[SLOT_W-1:0];
					lk_wdata = free_head_q;
					dt_re    = 1'b1;
					dt_addr  = cur_head[SLOT_W-1:0];
					head_ld  = 1'b1;
				end
			end
			BK_LINK: begin
				if (out_ready) begin
					fin      = 1'b1;
					fin_data = drd_q;
					qp_we    = 1'b1;
					qp_wdata = {lrd_q, cur_tail};
					fh_we    = 1'b1;
					fh_d     = head_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (qp_we) begin
			qptr_mem[qp_addr] <= qp_wdata;
		end
		if (qp_re) begin
			qrd_q <= qptr_mem[qp_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lk_we) begin
			link_mem[lk_addr] <= lk_wdata;
		end
		if (lk_re) begin
			lrd_q <= link_mem[lk_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dt_we) begin
			data_mem[dt_addr] <= item_s1.din;
		end
		if (dt_re) begin
			drd_q <= data_mem[dt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_s1 <= item;
		end
		if (head_ld) begin
			head_q <= cur_head;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_data_q   <= fin_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			free_head_q <= '0;
			fresh_q     <= '0;
			qvalid_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fh_we) begin
				free_head_q <= fh_d;
			end
			if (fresh_inc) begin
				fresh_q <= fresh_q + PTR_W'(1);
			end
			if (qv_set) begin
				qvalid_q[qidx] <= 1'b1;
			end
			if (fin) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign res_status = res_status_q;
	assign res_data   = res_data_q;

endmodule

/* hw/rtl/shared_buffer_multi_queue.sv */
// top level of the shared buffer multi-queue: config register, front and back
// depends on sbmq_pkg, sbmq_front, sbmq_back
`timescale 1ns / 1ps

// usage
// - input channel in_valid / in_stall carries one item: opcode (enqueue or
//   dequeue), queue_id and data_in; an item is taken when in_valid is high and
//   in_stall is low
// - output channel out_valid / out_stall returns exactly one result per item,
//   in order: status and data_out
// - the config port holds active_queues at byte address 0; write it only while
//   no item is in flight
// - from accept to out_valid, idle block: the front queue entry, then the back
//   states BK_IDLE and BK_PTR for enqueue and any rejected item, and BK_LINK too
//   for a successful dequeue; the back end reads the queue pointer memory, then
//   the link memory, and writes back before taking the next item, so it takes no
//   new item before it is through with the last
// - a two-entry queue sits between front and back, so up to two items are
//   taken while the back is busy or the result waits
// - reset: all queues empty, every slot on the free list, active_queues = 8;
//   no clearing pass, the link memory is covered by a fresh-slot count
// - out_stall holds the result register; the back end then waits and the
//   input queue fills and raises in_stall

module shared_buffer_multi_queue #(
	parameter int NUM_SLOTS  = sbmq_pkg::DEF_NUM_SLOTS,
	parameter int NUM_QUEUES = sbmq_pkg::DEF_NUM_QUEUES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [sbmq_pkg::QID_IN_W-1:0] queue_id,
	input  logic [sbmq_pkg::DATA_W-1:0]   data_in,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [sbmq_pkg::DATA_W-1:0]   data_out
);
	import sbmq_pkg::*;

	logic [AQ_W-1:0] active_queues_q;
	logic            cfg_wr;
	logic            item_valid;
	logic            item_pop;
	item_t           item;

	// config register: word index in paddr[2], byte offset ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_QUEUES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_queues_q <= ACTIVE_QUEUES_RST;
		end else if (cfg_wr) begin
			active_queues_q <= pwdata[AQ_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ACTIVE_QUEUES) ? {{(32-AQ_W){1'b0}}, active_queues_q}
		: 32'h0;

	// front: accept, flag bad queue index, buffer
	sbmq_front #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.queue_id      (queue_id),
		.data_in       (data_in),
		.active_queues (active_queues_q),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop)
	);

	// back: linked-list update and result register
	sbmq_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_stall  (out_stall),
		.res_valid  (out_valid),
		.res_status (status),
		.res_data   (data_out)
	);

endmodule

/* hw/rtl/sbmq_checker.sv */
// port-level checks for shared_buffer_multi_queue, bound to the top level
// depends on sbmq_pkg and shared_buffer_multi_queue_defines.svh
`timescale 1ns / 1ps
`include "shared_buffer_multi_queue_defines.svh"

module sbmq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  status,
	input logic [sbmq_pkg::DATA_W-1:0] data_out
);
	import sbmq_pkg::*;

	// any failed item reports all ones
	`SBMQ_ASSERT_NOW(a_err_data, clk, arst_n, out_valid && (status != ST_OK), data_out == ERR_DATA, "failed item without all-ones data")

	// a held result does not move
	`SBMQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(data_out), "result changed under stall")

	// the input queue only fills through an offered item
	`SBMQ_ASSERT_NOW(a_stall_fill, clk, arst_n, in_stall, $past(in_stall) || $past(in_valid), "stall rose with no item offered")

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);
